@@ hdl/mctt_pkg.sv @@
// Shared definitions for the multi-channel tick timer bank.
// Holds command codes, field widths, default sizes and the control structs
// passed between the controller and the datapath. Depends on nothing.
package mctt_pkg;

    localparam int DEF_NUM_TIMERS = 8;
    localparam int MASK_W         = 8;
    localparam int TICK_W         = 32;
    localparam int CMD_W          = 2;
    localparam int INDEX_W        = 3;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    typedef struct packed {
        logic begin_item;
        logic tick;
        logic start;
        logic stop;
        logic step;
        logic publish;
    } mctt_cmd_t;

    typedef struct packed {
        logic walk_last;
    } mctt_sts_t;

endpackage

@@ hdl/multi_channel_tick_timer_bank.sv @@
// Top level of the multi-channel tick timer bank.
// Joins the controller mctt_ctrl and the datapath mctt_dp. Depends on mctt_pkg.
//
// The input channel takes one command beat: a tick, or a start or stop of one
// timer slot. A start arms the slot with its reload period and repeat count
// (zero repeats for ever) and clears its counter; a stop disarms it. Indices
// at or above NUM_TIMERS are ignored, as is command code three.
// Every input beat yields exactly one result beat on the output channel: the
// slots that fired and that disarmed themselves on a tick, the armed slots
// and the system tick count.
// A start or stop beat passes through the done state, which loads the output
// register and raises m_valid once that register is free. A tick first walks
// the slot store one slot per cycle, then passes through the done state. s_ready
// is high only while no beat is in work and rises together with m_valid, so a
// new beat is taken only after the previous one has loaded its result.
// The result sits in an output register, so a new beat is accepted while the
// previous result waits; if the receiver stalls, the finished item waits
// until that register is free and no further beat is accepted meanwhile.
// Reset disarms all slots, clears the tick count and empties the output.
module multi_channel_tick_timer_bank #(
    parameter int NUM_TIMERS = mctt_pkg::DEF_NUM_TIMERS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mctt_pkg::CMD_W-1:0]    s_command,
    input  logic [mctt_pkg::INDEX_W-1:0]  s_timer_index,
    input  logic [mctt_pkg::TICK_W-1:0]   s_reload_value,
    input  logic [mctt_pkg::TICK_W-1:0]   s_repeat_count,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mctt_pkg::MASK_W-1:0]   m_fired_mask,
    output logic [mctt_pkg::MASK_W-1:0]   m_stopped_mask,
    output logic [mctt_pkg::MASK_W-1:0]   m_active_mask,
    output logic [mctt_pkg::TICK_W-1:0]   m_tick_count
);
    import mctt_pkg::*;

    mctt_cmd_t ctrl_cmd;
    mctt_sts_t dp_sts;

    mctt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .ctrl_cmd  (ctrl_cmd),
        .dp_sts    (dp_sts)
    );

    mctt_dp #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl_cmd       (ctrl_cmd),
        .dp_sts         (dp_sts),
        .s_timer_index  (s_timer_index),
        .s_reload_value (s_reload_value),
        .s_repeat_count (s_repeat_count),
        .m_fired_mask   (m_fired_mask),
        .m_stopped_mask (m_stopped_mask),
        .m_active_mask  (m_active_mask),
        .m_tick_count   (m_tick_count)
    );

    a_tick_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == CMD_TICK) |=> !s_ready)
        else $error("Input accepted during a slot walk.");

    a_stop_implies_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_stopped_mask & ~m_fired_mask) == '0))
        else $error("Slot disarmed itself without firing.");

    a_stopped_not_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_stopped_mask & m_active_mask) == '0))
        else $error("Self-disarmed slot still shown as armed.");

    a_walk_one_per_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_cmd.publish) |=> (m_valid && !ctrl_cmd.step))
        else $error("Result register not loaded after completion.");

endmodule

@@ hdl/mctt_ctrl.sv @@
// Controller state machine of the timer bank.
// Sequences item acceptance, the slot walk on ticks and the result register.
// Depends on mctt_pkg.
module mctt_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mctt_pkg::CMD_W-1:0]   s_command,
    output logic                         m_valid,
    input  logic                         m_ready,
    output mctt_pkg::mctt_cmd_t          ctrl_cmd,
    input  mctt_pkg::mctt_sts_t          dp_sts
);
    import mctt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        ctrl_cmd     = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ctrl_cmd.begin_item = 1'b1;
                    case (s_command)
                        CMD_TICK: begin
                            ctrl_cmd.tick = 1'b1;
                            state_next    = ST_WALK;
                        end
                        CMD_START: begin
                            ctrl_cmd.start = 1'b1;
                            state_next     = ST_DONE;
                        end
                        CMD_STOP: begin
                            ctrl_cmd.stop = 1'b1;
                            state_next    = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                ctrl_cmd.step = 1'b1;
                if (dp_sts.walk_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    ctrl_cmd.publish = 1'b1;
                    m_valid_next     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ hdl/mctt_dp.sv @@
// Datapath of the timer bank: slot store, walk index, tick count, result beat.
// Acts only on the command struct from mctt_ctrl. Depends on mctt_pkg.
module mctt_dp #(
    parameter int NUM_TIMERS = mctt_pkg::DEF_NUM_TIMERS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mctt_pkg::mctt_cmd_t           ctrl_cmd,
    output mctt_pkg::mctt_sts_t           dp_sts,
    input  logic [mctt_pkg::INDEX_W-1:0]  s_timer_index,
    input  logic [mctt_pkg::TICK_W-1:0]   s_reload_value,
    input  logic [mctt_pkg::TICK_W-1:0]   s_repeat_count,
    output logic [mctt_pkg::MASK_W-1:0]   m_fired_mask,
    output logic [mctt_pkg::MASK_W-1:0]   m_stopped_mask,
    output logic [mctt_pkg::MASK_W-1:0]   m_active_mask,
    output logic [mctt_pkg::TICK_W-1:0]   m_tick_count
);
    import mctt_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    logic [NUM_TIMERS-1:0] armed_reg;
    logic [TICK_W-1:0]     counter_reg   [NUM_TIMERS];
    logic [TICK_W-1:0]     period_reg    [NUM_TIMERS];
    logic [TICK_W-1:0]     remaining_reg [NUM_TIMERS];
    logic [IDX_W-1:0]      walk_idx_reg;
    logic [TICK_W-1:0]     ticks_reg;
    logic [MASK_W-1:0]     fired_acc_reg;
    logic [MASK_W-1:0]     stopped_acc_reg;
    logic [MASK_W-1:0]     fired_reg;
    logic [MASK_W-1:0]     stopped_reg;
    logic [MASK_W-1:0]     active_reg;
    logic [TICK_W-1:0]     tick_out_reg;

    logic [NUM_TIMERS-1:0] slot_hit;
    logic [MASK_W-1:0]     armed_view;
    logic                  cur_armed;
    logic [TICK_W-1:0]     cur_period;
    logic [TICK_W-1:0]     cur_remaining;
    logic [TICK_W-1:0]     count_inc;
    logic                  live;
    logic                  fire;
    logic                  has_repeat;
    logic                  auto_stop;

    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_hit
        assign slot_hit[g] = ({{(32-INDEX_W){1'b0}}, s_timer_index} == 32'(g));
    end

    for (genvar g = 0; g < MASK_W; g++) begin : g_view
        if (g < NUM_TIMERS) begin : g_on
            assign armed_view[g] = armed_reg[g];
        end else begin : g_off
            assign armed_view[g] = 1'b0;
        end
    end

    assign cur_armed     = armed_reg[walk_idx_reg];
    assign cur_period    = period_reg[walk_idx_reg];
    assign cur_remaining = remaining_reg[walk_idx_reg];
    assign count_inc     = counter_reg[walk_idx_reg] + TICK_W'(1);
    assign live          = cur_armed && (cur_period != '0);
    assign fire          = live && (count_inc >= cur_period);
    assign has_repeat    = (cur_remaining != '0);
    assign auto_stop     = fire && (cur_remaining == TICK_W'(1));

    assign dp_sts.walk_last = (walk_idx_reg == LAST_IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (ctrl_cmd.start && slot_hit[i]) begin
                    armed_reg[i] <= 1'b1;
                end else if (ctrl_cmd.stop && slot_hit[i]) begin
                    armed_reg[i] <= 1'b0;
                end else if (ctrl_cmd.step && auto_stop && walk_idx_reg == IDX_W'(i)) begin
                    armed_reg[i] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (ctrl_cmd.start && slot_hit[i]) begin
                counter_reg[i]   <= '0;
                period_reg[i]    <= s_reload_value;
                remaining_reg[i] <= s_repeat_count;
            end else if (ctrl_cmd.step && live && walk_idx_reg == IDX_W'(i)) begin
                counter_reg[i] <= fire ? '0 : count_inc;
                if (fire && has_repeat) begin
                    remaining_reg[i] <= cur_remaining - TICK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg    <= '0;
            walk_idx_reg <= '0;
        end else begin
            if (ctrl_cmd.tick) begin
                ticks_reg    <= ticks_reg + TICK_W'(1);
                walk_idx_reg <= '0;
            end else if (ctrl_cmd.step && !dp_sts.walk_last) begin
                walk_idx_reg <= walk_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_cmd.begin_item) begin
            fired_acc_reg   <= '0;
            stopped_acc_reg <= '0;
        end else if (ctrl_cmd.step) begin
            for (int i = 0; i < MASK_W; i++) begin
                if (i < NUM_TIMERS && walk_idx_reg == IDX_W'(i)) begin
                    if (fire) begin
                        fired_acc_reg[i] <= 1'b1;
                    end
                    if (auto_stop) begin
                        stopped_acc_reg[i] <= 1'b1;
                    end
                end
            end
        end
        if (ctrl_cmd.publish) begin
            fired_reg    <= fired_acc_reg;
            stopped_reg  <= stopped_acc_reg;
            active_reg   <= armed_view;
            tick_out_reg <= ticks_reg;
        end
    end

    assign m_fired_mask   = fired_reg;
    assign m_stopped_mask = stopped_reg;
    assign m_active_mask  = active_reg;
    assign m_tick_count   = tick_out_reg;

endmodule

@@ dv/mctt_checker.sv @@
// Result checker for the multi-channel tick timer bank testbench.
// Watches both channels, predicts each result beat from the accepted command
// beats and compares it field by field. Depends on mctt_pkg.
`timescale 1ns / 100ps

module mctt_checker #(
    parameter int NUM_TIMERS = mctt_pkg::DEF_NUM_TIMERS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [mctt_pkg::CMD_W-1:0]    s_command,
    input  logic [mctt_pkg::INDEX_W-1:0]  s_timer_index,
    input  logic [mctt_pkg::TICK_W-1:0]   s_reload_value,
    input  logic [mctt_pkg::TICK_W-1:0]   s_repeat_count,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [mctt_pkg::MASK_W-1:0]   m_fired_mask,
    input  logic [mctt_pkg::MASK_W-1:0]   m_stopped_mask,
    input  logic [mctt_pkg::MASK_W-1:0]   m_active_mask,
    input  logic [mctt_pkg::TICK_W-1:0]   m_tick_count,
    output int                            fail_count,
    output int                            outstanding,
    output int                            beats_checked,
    output int                            firings_seen
);
    import mctt_pkg::*;

    typedef struct packed {
        logic [MASK_W-1:0] fired;
        logic [MASK_W-1:0] stopped;
        logic [MASK_W-1:0] active;
        logic [TICK_W-1:0] ticks;
    } timer_result_t;

    logic              armed_q     [NUM_TIMERS];
    logic [TICK_W-1:0] counter_q   [NUM_TIMERS];
    logic [TICK_W-1:0] period_q    [NUM_TIMERS];
    logic [TICK_W-1:0] remaining_q [NUM_TIMERS];
    logic [TICK_W-1:0] ticks_q;

    timer_result_t expected_results[$];
    timer_result_t predicted;
    timer_result_t want;
    timer_result_t got;
    int            mismatches = 0;
    int            checked = 0;
    int            firings = 0;

    task automatic advance_timer_bank(
        input  logic [CMD_W-1:0]   cmd,
        input  logic [INDEX_W-1:0] idx,
        input  logic [TICK_W-1:0]  reload,
        input  logic [TICK_W-1:0]  rpt,
        output timer_result_t      res
    );
        logic [MASK_W-1:0] fired;
        logic [MASK_W-1:0] stopped;
        logic [MASK_W-1:0] active;
        fired   = '0;
        stopped = '0;
        active  = '0;
        if (cmd == CMD_TICK) begin
            ticks_q = ticks_q + 1;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                if (armed_q[i] && period_q[i] != 0) begin
                    counter_q[i] = counter_q[i] + 1;
                    if (counter_q[i] >= period_q[i]) begin
                        if (i < MASK_W) fired[i] = 1'b1;
                        counter_q[i] = '0;
                        if (remaining_q[i] != 0) begin
                            remaining_q[i] = remaining_q[i] - 1;
                            if (remaining_q[i] == 0) begin
                                armed_q[i] = 1'b0;
                                if (i < MASK_W) stopped[i] = 1'b1;
                            end
                        end
                    end
                end
            end
        end else if (cmd == CMD_START) begin
            if (idx < NUM_TIMERS) begin
                armed_q[idx]     = 1'b1;
                counter_q[idx]   = '0;
                period_q[idx]    = reload;
                remaining_q[idx] = rpt;
            end
        end else if (cmd == CMD_STOP) begin
            if (idx < NUM_TIMERS) armed_q[idx] = 1'b0;
        end
        for (int i = 0; i < NUM_TIMERS && i < MASK_W; i++) begin
            active[i] = armed_q[i];
        end
        res = '{fired, stopped, active, ticks_q};
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                armed_q[i]     = 1'b0;
                counter_q[i]   = '0;
                period_q[i]    = '0;
                remaining_q[i] = '0;
            end
            ticks_q = '0;
            expected_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                advance_timer_bank(s_command, s_timer_index, s_reload_value,
                                   s_repeat_count, predicted);
                expected_results.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                got = '{m_fired_mask, m_stopped_mask, m_active_mask, m_tick_count};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("[%0t] unexpected result beat:", $realtime);
                        $display("    actual   fired=%h stopped=%h active=%h ticks=%h",
                                 got.fired, got.stopped, got.active, got.ticks);
                    end
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    firings += $countones(want.fired);
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] result beat %0d mismatch:", $realtime, checked);
                            $display("    expected fired=%h stopped=%h active=%h ticks=%h",
                                     want.fired, want.stopped, want.active, want.ticks);
                            $display("    actual   fired=%h stopped=%h active=%h ticks=%h",
                                     got.fired, got.stopped, got.active, got.ticks);
                        end
                    end
                end
            end
        end
        fail_count    <= mismatches;
        outstanding   <= expected_results.size();
        beats_checked <= checked;
        firings_seen  <= firings;
    end

endmodule

@@ dv/tb_multi_channel_tick_timer_bank.sv @@
// Top of the multi-channel tick timer bank testbench.
// Drives directed and random command beats with bursty traffic and a stalling
// receiver, and gives the verdict. Depends on mctt_pkg and mctt_checker.
`timescale 1ns / 100ps

module tb_multi_channel_tick_timer_bank;
    import mctt_pkg::*;

    localparam int               NUM_TIMERS   = DEF_NUM_TIMERS;
    localparam int               RANDOM_BEATS = 1200;
    localparam int               RUN_LIMIT    = 500000;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command      = '0;
    logic [INDEX_W-1:0]  s_timer_index  = '0;
    logic [TICK_W-1:0]   s_reload_value = '0;
    logic [TICK_W-1:0]   s_repeat_count = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [MASK_W-1:0]   m_fired_mask;
    logic [MASK_W-1:0]   m_stopped_mask;
    logic [MASK_W-1:0]   m_active_mask;
    logic [TICK_W-1:0]   m_tick_count;

    int fail_count;
    int outstanding;
    int beats_checked;
    int firings_seen;
    int beats_sent  = 0;
    int cycle_count = 0;
    int ready_hold  = 0;

    always #1 aclk = ~aclk;

    multi_channel_tick_timer_bank #(
        .NUM_TIMERS(NUM_TIMERS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_timer_index  (s_timer_index),
        .s_reload_value (s_reload_value),
        .s_repeat_count (s_repeat_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fired_mask   (m_fired_mask),
        .m_stopped_mask (m_stopped_mask),
        .m_active_mask  (m_active_mask),
        .m_tick_count   (m_tick_count)
    );

    mctt_checker #(
        .NUM_TIMERS(NUM_TIMERS)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_timer_index  (s_timer_index),
        .s_reload_value (s_reload_value),
        .s_repeat_count (s_repeat_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fired_mask   (m_fired_mask),
        .m_stopped_mask (m_stopped_mask),
        .m_active_mask  (m_active_mask),
        .m_tick_count   (m_tick_count),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .beats_checked  (beats_checked),
        .firings_seen   (firings_seen)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, outstanding);
            $display("** multi_channel_tick_timer_bank: FAILED **");
            $finish;
        end
    end

    // The receiver alternates between runs of readiness and short stalls.
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 2) != 0) begin
            m_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 25);
        end else begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 8);
        end
    end

    task automatic send_beat(
        input logic [CMD_W-1:0]   cmd,
        input logic [INDEX_W-1:0] idx,
        input logic [TICK_W-1:0]  reload,
        input logic [TICK_W-1:0]  rpt
    );
        s_valid        <= 1'b1;
        s_command      <= cmd;
        s_timer_index  <= idx;
        s_reload_value <= reload;
        s_repeat_count <= rpt;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic wait_for_results();
        do @(posedge aclk); while (outstanding != 0);
    endtask

    initial begin
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] idx;
        logic [TICK_W-1:0]  reload;
        logic [TICK_W-1:0]  rpt;
        int                 sel;
        int                 burst;
        int                 target;
        bit                 paused;

        paused = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_beat(CMD_TICK,  3'd0, 32'h0000_0000, 32'h0000_0000);
        send_beat(CMD_START, 3'd0, 32'd1, 32'd1);
        send_beat(CMD_TICK,  3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_START, 3'd1, 32'd0, 32'd0);
        send_beat(CMD_START, 3'd2, 32'd2, 32'd0);
        send_beat(CMD_TICK,  3'd0, 32'h5555_5555, 32'hAAAA_AAAA);
        send_beat(CMD_TICK,  3'd0, 32'hAAAA_AAAA, 32'h5555_5555);
        send_beat(CMD_START, 3'd2, 32'd3, 32'd2);
        send_beat(CMD_STOP,  3'd3, 32'h0000_0000, 32'h0000_0000);
        send_beat(CMD_START, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_START, 3'd5, 32'd1, 32'hFFFF_FFFF);
        send_beat(CMD_START, 3'd6, 32'd1, 32'd3);
        send_beat(CMD_TICK,  3'd0, 32'h0000_0000, 32'h0000_0000);
        send_beat(CMD_UNUSED, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_TICK,  3'd0, 32'h0000_0000, 32'h0000_0000);
        send_beat(CMD_TICK,  3'd0, 32'h0000_0000, 32'h0000_0000);
        send_beat(CMD_STOP,  3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_START, 3'd4, 32'h8000_0000, 32'h0000_0001);
        send_beat(CMD_STOP,  3'd7, 32'h0000_0000, 32'h0000_0000);
        send_beat(CMD_TICK,  3'd0, 32'h0000_0000, 32'h0000_0000);
        send_beat(CMD_STOP,  3'd0, 32'h0000_0000, 32'h0000_0000);
        send_beat(CMD_TICK,  3'd0, 32'h0000_0000, 32'h0000_0000);
        send_beat(CMD_START, 3'd3, 32'd2, 32'd1);
        send_beat(CMD_TICK,  3'd0, 32'h0000_0000, 32'h0000_0000);
        send_beat(CMD_TICK,  3'd0, 32'h0000_0000, 32'h0000_0000);
        s_valid <= 1'b0;
        wait_for_results();

        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target) begin
            burst = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 10);
            for (int b = 0; b < burst; b++) begin
                sel = $urandom_range(0, 99);
                if (sel < 50) cmd = CMD_TICK;
                else if (sel < 75) cmd = CMD_START;
                else if (sel < 94) cmd = CMD_STOP;
                else cmd = CMD_UNUSED;
                idx    = INDEX_W'($urandom_range(0, 7));
                reload = $urandom;
                rpt    = $urandom;
                if (cmd == CMD_START) begin
                    sel = $urandom_range(0, 9);
                    if (sel == 0) reload = '0;
                    else if (sel > 1) reload = $urandom_range(1, 6);
                    sel = $urandom_range(0, 9);
                    if (sel < 2) rpt = '0;
                    else if (sel > 2) rpt = $urandom_range(1, 5);
                end
                send_beat(cmd, idx, reload, rpt);
            end
            s_valid <= 1'b0;
            if (!paused && beats_sent >= target - RANDOM_BEATS / 2) begin
                paused = 1'b1;
                wait_for_results();
            end
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end

        wait_for_results();
        repeat (NUM_TIMERS + 6) @(posedge aclk);
        $display("Run covered %0d command beats and %0d checked result beats,",
                 beats_sent, beats_checked);
        $display("with %0d slot firings and a full drain of results mid-run.", firings_seen);
        if (fail_count == 0 && outstanding == 0) begin
            $display("** multi_channel_tick_timer_bank: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results outstanding", fail_count, outstanding);
            $display("** multi_channel_tick_timer_bank: FAILED **");
        end
        $finish;
    end

endmodule
